@@ hw/rtl/kchd_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package kchd_pkg;

	localparam int TimerWidth = 32;
	localparam int PollWidth  = 8;
	localparam int ThrWidth   = 16;
	localparam int HoldWidth  = 32;
	localparam int ClickWidth = 8;
	localparam int CfgIdxWidth = 2;

	typedef logic [TimerWidth-1:0] tmr_t;
	typedef logic [TimerWidth:0]   tmr_ext_t;
	typedef logic [ClickWidth-1:0] clicks_t;

	typedef enum logic [2:0] {
		ModeIdle    = 3'd0,
		ModePre     = 3'd1,
		ModePressed = 3'd2,
		ModeHold    = 3'd3,
		ModeWait    = 3'd4
	} mode_t;

	typedef enum logic [1:0] {
		EvPress  = 2'd0,
		EvHold   = 2'd1,
		EvClicks = 2'd2
	} ev_t;

	typedef enum logic [CfgIdxWidth-1:0] {
		CfgPollPeriod     = 2'd0,
		CfgClickThreshold = 2'd1,
		CfgHoldThreshold  = 2'd2,
		CfgIntervalLimit  = 2'd3
	} cfg_idx_t;

	typedef struct packed {
		logic [PollWidth-1:0] poll_period;
		logic [ThrWidth-1:0]  click_threshold;
		logic [ThrWidth-1:0]  hold_threshold;
		logic [ThrWidth-1:0]  interval_limit;
	} cfg_t;

	typedef struct packed {
		ev_t                   event_res;
		logic [HoldWidth-1:0]  hold_time;
		logic [ClickWidth-1:0] click_total;
	} result_t;

	function automatic tmr_t sat_add(tmr_t t, logic [PollWidth-1:0] inc);
		tmr_ext_t s;
		s = {1'b0, t} + tmr_ext_t'(inc);
		return s[TimerWidth] ? '1 : s[TimerWidth-1:0];
	endfunction

endpackage

`default_nettype wire

@@ hw/rtl/kchd_cfg_regs.sv @@
`timescale 1ns / 1ps
`default_nettype none

module kchd_cfg_regs (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [kchd_pkg::CfgIdxWidth-1:0] cfg_index,
	input  wire logic [kchd_pkg::ThrWidth-1:0]  cfg_data,
	output kchd_pkg::cfg_t                      cfg
);

	kchd_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.poll_period     <= kchd_pkg::PollWidth'(1);
			cfg_q.click_threshold <= kchd_pkg::ThrWidth'(20);
			cfg_q.hold_threshold  <= kchd_pkg::ThrWidth'(1000);
			cfg_q.interval_limit  <= kchd_pkg::ThrWidth'(300);
		end else if (cfg_we) begin
			unique case (kchd_pkg::cfg_idx_t'(cfg_index))
				kchd_pkg::CfgPollPeriod: begin
					cfg_q.poll_period <= cfg_data[kchd_pkg::PollWidth-1:0];
				end
				kchd_pkg::CfgClickThreshold: begin
					cfg_q.click_threshold <= cfg_data;
				end
				kchd_pkg::CfgHoldThreshold: begin
					cfg_q.hold_threshold <= cfg_data;
				end
				kchd_pkg::CfgIntervalLimit: begin
					cfg_q.interval_limit <= cfg_data;
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

@@ hw/rtl/kchd_core.sv @@
`timescale 1ns / 1ps
`default_nettype none

module kchd_core (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  kchd_pkg::cfg_t    cfg,
	input  wire logic         tick,
	input  wire logic         pressed,
	output logic              res_valid,
	output kchd_pkg::result_t res
);

	kchd_pkg::mode_t   mode_q, mode_nx;
	kchd_pkg::tmr_t    press_q, press_nx;
	kchd_pkg::tmr_t    gap_q, gap_nx;
	kchd_pkg::clicks_t clicks_q, clicks_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= kchd_pkg::ModeIdle;
			press_q  <= '0;
			gap_q    <= '0;
			clicks_q <= '0;
		end else if (tick) begin
			mode_q   <= mode_nx;
			press_q  <= press_nx;
			gap_q    <= gap_nx;
			clicks_q <= clicks_nx;
		end
	end

	always_comb begin
		mode_nx   = mode_q;
		clicks_nx = clicks_q;
		res_valid = 1'b0;
		res       = '0;
		press_nx  = pressed ? kchd_pkg::sat_add(press_q, cfg.poll_period) : '0;
		gap_nx    = (mode_q == kchd_pkg::ModeWait) ?
			kchd_pkg::sat_add(gap_q, cfg.poll_period) : '0;
		unique case (mode_q)
			kchd_pkg::ModePre: begin
				if (!pressed) begin
					mode_nx = kchd_pkg::ModeIdle;
				end else if (press_nx > kchd_pkg::tmr_t'(cfg.click_threshold)) begin
					mode_nx       = kchd_pkg::ModePressed;
					res_valid     = tick;
					res.event_res = kchd_pkg::EvPress;
				end
			end
			kchd_pkg::ModePressed: begin
				if (!pressed) begin
					mode_nx = kchd_pkg::ModeWait;
					if (clicks_q != '1) begin
						clicks_nx = clicks_q + kchd_pkg::clicks_t'(1);
					end
				end else if (press_nx > kchd_pkg::tmr_t'(cfg.hold_threshold)) begin
					mode_nx = kchd_pkg::ModeHold;
				end
			end
			kchd_pkg::ModeHold: begin
				if (!pressed) begin
					mode_nx       = kchd_pkg::ModeIdle;
					res_valid     = tick;
					res.event_res = kchd_pkg::EvHold;
					res.hold_time = kchd_pkg::HoldWidth'(press_q);
				end
			end
			kchd_pkg::ModeWait: begin
				if (gap_nx > kchd_pkg::tmr_t'(cfg.interval_limit)) begin
					mode_nx         = kchd_pkg::ModeIdle;
					res_valid       = tick;
					res.event_res   = kchd_pkg::EvClicks;
					res.click_total = clicks_q;
				end else if (press_nx > kchd_pkg::tmr_t'(cfg.click_threshold)) begin
					mode_nx = kchd_pkg::ModePressed;
				end
			end
			default: begin
				clicks_nx = '0;
				mode_nx   = pressed ? kchd_pkg::ModePre : kchd_pkg::ModeIdle;
			end
		endcase
	end

endmodule

`default_nettype wire

@@ hw/rtl/kchd_out_fifo.sv @@
`timescale 1ns / 1ps
`default_nettype none

module kchd_out_fifo (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         push,
	input  kchd_pkg::result_t push_data,
	output logic              has_room,
	output logic              out_valid,
	input  wire logic         out_ready,
	output kchd_pkg::result_t out_data
);

	kchd_pkg::result_t slot_q [2];
	logic              wr_ptr_q;
	logic              rd_ptr_q;
	logic [1:0]        count_q;
	logic              pop;

	assign pop       = out_valid && out_ready;
	assign out_valid = (count_q != 2'd0);
	assign has_room  = !count_q[1];
	assign out_data  = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			if (push && !pop) begin
				count_q <= count_q + 2'd1;
			end else if (pop && !push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/key_click_hold_detector_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Click and hold detector for one key. Every transfer on the slave side is one polling tick
// carrying the key level, and the block takes one tick per clock cycle while s_tready is high.
// A tick that detects a press, releases a long hold or ends a click sequence writes one event
// into a two-entry output buffer, and that event shows on the master side in the following
// cycle when the buffer was empty; all other ticks produce nothing. Ticks keep flowing while an
// event is pending, and s_tready drops only while two events are waiting. Configuration
// writes must be made while no tick is in flight.
module key_click_hold_detector_unit (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_we,
	input  wire logic [kchd_pkg::CfgIdxWidth-1:0] cfg_index,
	input  wire logic [kchd_pkg::ThrWidth-1:0]    cfg_data,
	input  wire logic                             s_tvalid,
	output logic                                  s_tready,
	input  wire logic [7:0]                       s_tdata,  // [0] pressed
	output logic                                  m_tvalid,
	input  wire logic                             m_tready,
	output logic [39:0]                           m_tdata,  // [31:0] hold_time, [39:32] click_total
	output logic [1:0]                            m_tuser   // [1:0] event_res
);

	kchd_pkg::cfg_t    cfg;
	kchd_pkg::result_t res;
	kchd_pkg::result_t out_res;
	logic              tick;
	logic              res_valid;

	assign tick = s_tvalid && s_tready;

	kchd_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	kchd_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.tick      (tick),
		.pressed   (s_tdata[0]),
		.res_valid (res_valid),
		.res       (res)
	);

	kchd_out_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_valid),
		.push_data (res),
		.has_room  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_data  (out_res)
	);

	assign m_tdata = {out_res.click_total, out_res.hold_time};
	assign m_tuser = out_res.event_res;

	a_event_needs_tick: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (s_tvalid && s_tready))
		else $error("event raised without an accepted tick");

	a_empty_is_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled while output buffer is empty");

	a_event_shows_next: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |=> m_tvalid)
		else $error("event not presented after its tick");

	a_hold_no_clicks: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tuser == kchd_pkg::EvHold)) |-> (m_tdata[39:32] == 8'd0))
		else $error("hold event carries a click count");

endmodule

`default_nettype wire

@@ tb/sv/tb_key_click_hold_detector_unit.sv @@
`timescale 1ns / 1ps

module tb_key_click_hold_detector_unit;

	localparam int CLK_PERIOD = 4;
	localparam int RESET_CYCLES = 8;
	localparam int SETTLE_CYCLES = 10;
	localparam int LONG_STALL_CYCLES = 300;
	localparam int CYCLE_LIMIT = 400000;

	class click_hold_scoreboard;
		kchd_pkg::cfg_t cfg;
		kchd_pkg::mode_t mode;
		kchd_pkg::tmr_t press_tmr;
		kchd_pkg::tmr_t gap_tmr;
		kchd_pkg::clicks_t clicks;
		kchd_pkg::result_t events_due[$];
		int unsigned errors;

		function new();
			cfg.poll_period = 8'd1;
			cfg.click_threshold = 16'd20;
			cfg.hold_threshold = 16'd1000;
			cfg.interval_limit = 16'd300;
			mode = kchd_pkg::ModeIdle;
			press_tmr = '0;
			gap_tmr = '0;
			clicks = '0;
			errors = 0;
		endfunction

		function void write_reg(kchd_pkg::cfg_idx_t idx, logic [kchd_pkg::ThrWidth-1:0] val);
			case (idx)
				kchd_pkg::CfgPollPeriod: cfg.poll_period = val[kchd_pkg::PollWidth-1:0];
				kchd_pkg::CfgClickThreshold: cfg.click_threshold = val;
				kchd_pkg::CfgHoldThreshold: cfg.hold_threshold = val;
				kchd_pkg::CfgIntervalLimit: cfg.interval_limit = val;
				default: ;
			endcase
		endfunction

		function kchd_pkg::tmr_t advance(kchd_pkg::tmr_t t);
			logic [kchd_pkg::TimerWidth:0] sum;
			sum = {1'b0, t} + {{(kchd_pkg::TimerWidth - kchd_pkg::PollWidth + 1){1'b0}},
				cfg.poll_period};
			return sum[kchd_pkg::TimerWidth] ? '1 : sum[kchd_pkg::TimerWidth-1:0];
		endfunction

		// Works out the event, if any, that one accepted tick causes.
		function void note_tick(logic down);
			kchd_pkg::result_t ev;
			logic [kchd_pkg::HoldWidth-1:0] held;
			bit fire;
			ev = '0;
			held = '0;
			fire = 1'b0;
			if (!down) begin
				if (mode == kchd_pkg::ModeHold)
					held = press_tmr;
				press_tmr = '0;
			end else begin
				press_tmr = advance(press_tmr);
			end
			if (mode == kchd_pkg::ModeWait)
				gap_tmr = advance(gap_tmr);
			else
				gap_tmr = '0;
			case (mode)
				kchd_pkg::ModePre: begin
					if (!down) begin
						mode = kchd_pkg::ModeIdle;
					end else if (press_tmr > kchd_pkg::tmr_t'(cfg.click_threshold)) begin
						mode = kchd_pkg::ModePressed;
						ev.event_res = kchd_pkg::EvPress;
						fire = 1'b1;
					end
				end
				kchd_pkg::ModePressed: begin
					if (!down) begin
						mode = kchd_pkg::ModeWait;
						if (clicks != '1)
							clicks = clicks + kchd_pkg::clicks_t'(1);
					end else if (press_tmr > kchd_pkg::tmr_t'(cfg.hold_threshold)) begin
						mode = kchd_pkg::ModeHold;
					end
				end
				kchd_pkg::ModeHold: begin
					if (!down) begin
						mode = kchd_pkg::ModeIdle;
						ev.event_res = kchd_pkg::EvHold;
						ev.hold_time = held;
						fire = 1'b1;
					end
				end
				kchd_pkg::ModeWait: begin
					if (gap_tmr > kchd_pkg::tmr_t'(cfg.interval_limit)) begin
						mode = kchd_pkg::ModeIdle;
						ev.event_res = kchd_pkg::EvClicks;
						ev.click_total = clicks;
						fire = 1'b1;
					end else if (press_tmr > kchd_pkg::tmr_t'(cfg.click_threshold)) begin
						mode = kchd_pkg::ModePressed;
					end
				end
				default: begin
					clicks = '0;
					mode = down ? kchd_pkg::ModePre : kchd_pkg::ModeIdle;
				end
			endcase
			if (fire)
				events_due.push_back(ev);
		endfunction

		function void check_event(logic [1:0] ev_bits, logic [39:0] data);
			kchd_pkg::result_t want;
			if (events_due.size() == 0) begin
				$display("%0t: expected no event, got event_res %0d hold_time %0d click_total %0d",
					$time, ev_bits, data[31:0], data[39:32]);
				errors++;
				return;
			end
			want = events_due.pop_front();
			if (ev_bits != want.event_res) begin
				$display("%0t: event_res expected %0d, got %0d", $time, want.event_res, ev_bits);
				errors++;
			end
			if (data[31:0] != want.hold_time) begin
				$display("%0t: hold_time expected %0d, got %0d", $time, want.hold_time,
					data[31:0]);
				errors++;
			end
			if (data[39:32] != want.click_total) begin
				$display("%0t: click_total expected %0d, got %0d", $time, want.click_total,
					data[39:32]);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [kchd_pkg::CfgIdxWidth-1:0] cfg_index = '0;
	logic [kchd_pkg::ThrWidth-1:0] cfg_data = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [7:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [39:0] m_tdata;
	logic [1:0] m_tuser;

	click_hold_scoreboard sb = new();
	int unsigned burst_left = 1;
	bit long_stall_req = 1'b0;
	int unsigned stall_left = 0;
	int unsigned rx_cycle = 0;
	int unsigned cycle_count = 0;

	key_click_hold_detector_unit i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_event(m_tuser, m_tdata);
	end

	// The event sink cycles through always ready, coin flip, mostly stalled and mostly ready.
	always @(negedge clk) begin
		if (long_stall_req) begin
			long_stall_req = 1'b0;
			stall_left = LONG_STALL_CYCLES;
		end
		if (stall_left > 0) begin
			stall_left--;
			m_tready <= 1'b0;
		end else begin
			case (rx_cycle[7:6])
				2'd0: m_tready <= 1'b1;
				2'd1: m_tready <= 1'($urandom_range(0, 1));
				2'd2: m_tready <= ($urandom_range(0, 3) == 0);
				default: m_tready <= ($urandom_range(0, 3) != 0);
			endcase
		end
		rx_cycle++;
	end

	task automatic write_config(input logic [7:0] poll, input logic [15:0] click_thr,
		input logic [15:0] hold_thr, input logic [15:0] gap_lim);
		kchd_pkg::cfg_idx_t regs[4] = '{kchd_pkg::CfgPollPeriod, kchd_pkg::CfgClickThreshold,
			kchd_pkg::CfgHoldThreshold, kchd_pkg::CfgIntervalLimit};
		logic [15:0] vals[4];
		vals = '{{8'd0, poll}, click_thr, hold_thr, gap_lim};
		for (int i = 0; i < 4; i++) begin
			@(negedge clk);
			cfg_we <= 1'b1;
			cfg_index <= regs[i];
			cfg_data <= vals[i];
			sb.write_reg(regs[i], vals[i]);
		end
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic send_tick(input logic level);
		int unsigned gap;
		s_tdata <= {7'd0, level};
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		sb.note_tick(level);
		@(negedge clk);
		if (burst_left > 0)
			burst_left--;
		if (burst_left == 0) begin
			gap = $urandom_range(0, 6);
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(64, 200)
				: $urandom_range(1, 24);
		end
	endtask

	task automatic drain_events();
		s_tvalid <= 1'b0;
		while (sb.events_due.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Key gestures sized against the current thresholds: short taps, presses, long
	// holds, and releases either inside or past the click interval, with some noise.
	task automatic run_gestures(input int unsigned budget);
		int unsigned sent, press_len, rel_len, pick, step, click_t, hold_t, gap_t;
		step = (sb.cfg.poll_period == 0) ? 1 : sb.cfg.poll_period;
		click_t = sb.cfg.click_threshold / step + 1;
		hold_t = sb.cfg.hold_threshold / step + 2;
		gap_t = sb.cfg.interval_limit / step + 2;
		sent = 0;
		while (sent < budget) begin
			pick = $urandom_range(0, 99);
			if (pick < 10) begin
				send_tick(1'($urandom_range(0, 1)));
				sent++;
			end else begin
				if (pick < 35)
					press_len = $urandom_range(1, click_t);
				else if (pick < 75)
					press_len = $urandom_range(click_t, hold_t);
				else
					press_len = $urandom_range(hold_t, hold_t + 4);
				if ($urandom_range(0, 1) == 0)
					rel_len = $urandom_range(1, gap_t);
				else
					rel_len = $urandom_range(gap_t, gap_t + 4);
				repeat (press_len) send_tick(1'b1);
				repeat (rel_len) send_tick(1'b0);
				sent += press_len + rel_len;
			end
		end
	endtask

	initial begin
		string levels;
		levels = "1011011000011111101101111100";
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;

		// Short tap, two presses that make a double click, long hold, and a repeat
		// press inside the click wait that runs on into a long hold.
		write_config(8'd100, 16'd150, 16'd400, 16'd250);
		for (int i = 0; i < levels.len(); i++)
			send_tick(levels[i] == "1");
		drain_events();

		write_config(8'd1, 16'd2, 16'd8, 16'd4);
		run_gestures(60);
		drain_events();

		// Zero thresholds make events dense, so a long sink stall fills the block.
		write_config(8'd255, 16'd0, 16'd0, 16'd0);
		long_stall_req = 1'b1;
		run_gestures(80);
		drain_events();

		write_config(8'd7, 16'd20, 16'd60, 16'd30);
		run_gestures(50);
		drain_events();

		write_config(8'd200, 16'd1000, 16'd4000, 16'd1500);
		run_gestures(40);
		drain_events();

		// A long run of quick clicks, then a gap long enough to end the run.
		write_config(8'd1, 16'd0, 16'd2, 16'd1);
		send_tick(1'b1);
		repeat (24) begin
			send_tick(1'b1);
			send_tick(1'b0);
		end
		repeat (4) send_tick(1'b0);
		drain_events();

		// With no time added per tick a held key never leaves pre-press.
		write_config(8'd0, 16'd0, 16'd0, 16'd0);
		repeat (8) send_tick(1'b1);
		repeat (20) send_tick(1'($urandom_range(0, 1)));
		repeat (3) send_tick(1'b0);
		drain_events();

		write_config(8'd128, 16'd20, 16'd1000, 16'd300);
		run_gestures(30);
		drain_events();

		if (sb.errors == 0 && sb.events_due.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

@@ files.f @@
hw/rtl/kchd_pkg.sv
hw/rtl/kchd_cfg_regs.sv
hw/rtl/kchd_core.sv
hw/rtl/kchd_out_fifo.sv
hw/rtl/key_click_hold_detector_unit.sv
tb/sv/tb_key_click_hold_detector_unit.sv
